// ===== rtl/core/gnss_binary_frame_parser_core_macros.svh =====
// Assertion macros for the binary frame parser core.
// Included by RTL files that carry concurrent assertions; no other dependencies.
`ifndef GNSS_BINARY_FRAME_PARSER_CORE_MACROS_SVH
`define GNSS_BINARY_FRAME_PARSER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define GBFP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("gbfp assertion failed");

// Next-cycle implication, disabled while reset is active.
`define GBFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("gbfp assertion failed");

`endif

// ===== rtl/core/gbfp_pkg.sv =====
// Shared types and constants for the binary frame parser core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gbfp_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  localparam int unsigned LenRegW = 11;
  localparam int unsigned IdxW    = 10;
  localparam logic [LenRegW-1:0] MaxLenReset = 11'd608;

  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_GOOD     = 3'd1,
    ST_BAD_A    = 3'd2,
    ST_BAD_B    = 3'd3,
    ST_OVERSIZE = 3'd4
  } frame_status_e;

  // checksum control: load restarts both sums, fold accumulates one byte
  typedef struct packed {
    logic load;
    logic fold;
  } fletch_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/gbfp_fletcher.sv =====
// 8-bit Fletcher checksum accumulator (sum A and sum B registers).
// Depends on gbfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbfp_fletcher (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire gbfp_pkg::fletch_ctrl_t ctrl_i,
  input  wire logic [7:0]             data_i,
  output logic [7:0]                  sum_a_o,
  output logic [7:0]                  sum_b_o
);

  logic [7:0] sum_a_q, sum_a_d;
  logic [7:0] sum_b_q, sum_b_d;

  always_comb begin
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    if (ctrl_i.load) begin
      sum_a_d = data_i;
      sum_b_d = data_i;
    end else if (ctrl_i.fold) begin
      sum_a_d = sum_a_q + data_i;
      sum_b_d = sum_b_q + sum_a_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_a_q <= '0;
      sum_b_q <= '0;
    end else begin
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
    end
  end

  assign sum_a_o = sum_a_q;
  assign sum_b_o = sum_b_q;

endmodule

`default_nettype wire

// ===== rtl/core/gnss_binary_frame_parser_core.sv =====
// Each result is registered from its input transfer; one byte per cycle while in_stall_o is low.
// Throughput is one transfer per unstalled cycle, bounded by the phase and checksum register loop.
// The output register lets a new byte enter while the previous result is being taken.
// Reset (rst_ni low, asynchronous) returns to sync hunting, clears sums and captured
// header fields, empties the output register and loads the length limit with 608.
// Top level of the binary frame parser; depends on gbfp_pkg, gbfp_fletcher and the macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "gnss_binary_frame_parser_core_macros.svh"

module gnss_binary_frame_parser_core #(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [10:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             payload_valid_o,
  output logic [7:0]       payload_byte_o,
  output logic [9:0]       payload_index_o,
  output logic [2:0]       frame_status_o,
  output logic [7:0]       frame_class_o,
  output logic [7:0]       frame_id_o,
  output logic [10:0]      frame_length_o
);

  localparam int unsigned RegMax = (1 << gbfp_pkg::LenRegW) - 1;
  localparam int unsigned CapLim = (MAX_PAYLOAD < RegMax) ? MAX_PAYLOAD : RegMax;
  localparam int unsigned CntW   = $clog2(CapLim + 1);
  localparam logic [gbfp_pkg::LenRegW-1:0] CapLimV = gbfp_pkg::LenRegW'(CapLim);

  typedef enum logic [3:0] {
    PH_SYNC1  = 4'd0,
    PH_SYNC2  = 4'd1,
    PH_CLASS  = 4'd2,
    PH_ID     = 4'd3,
    PH_LEN_LO = 4'd4,
    PH_LEN_HI = 4'd5,
    PH_DATA   = 4'd6,
    PH_CK_A   = 4'd7,
    PH_CK_B   = 4'd8
  } phase_e;

  phase_e                           phase_q, phase_d;
  logic [gbfp_pkg::LenRegW-1:0]     max_len_q;
  logic [7:0]                       class_q, class_d;
  logic [7:0]                       id_q, id_d;
  logic [15:0]                      exp_len_q, exp_len_d;
  logic [CntW-1:0]                  cnt_q, cnt_d;

  logic                             out_valid_q;
  logic                             pv_q, pv_d;
  logic [7:0]                       pbyte_q, pbyte_d;
  logic [gbfp_pkg::IdxW-1:0]        pidx_q, pidx_d;
  gbfp_pkg::frame_status_e          status_q, status_d;
  logic [gbfp_pkg::LenRegW-1:0]     flen_q, flen_d;

  logic                             in_xfer;
  logic [gbfp_pkg::LenRegW-1:0]     limit;
  logic [15:0]                      limit_ext;
  logic [15:0]                      hi_len;
  logic [CntW-1:0]                  cnt_inc;
  gbfp_pkg::fletch_ctrl_t           fl_ctrl;
  logic [7:0]                       sum_a, sum_b;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign limit     = (max_len_q < CapLimV) ? max_len_q : CapLimV;
  assign limit_ext = 16'(limit);
  assign hi_len    = {rx_byte_i, exp_len_q[7:0]};
  assign cnt_inc   = cnt_q + 1'b1;

  gbfp_fletcher u_fletcher (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (fl_ctrl),
    .data_i  (rx_byte_i),
    .sum_a_o (sum_a),
    .sum_b_o (sum_b)
  );

  always_comb begin
    phase_d      = phase_q;
    class_d      = class_q;
    id_d         = id_q;
    exp_len_d    = exp_len_q;
    cnt_d        = cnt_q;
    pv_d         = 1'b0;
    pbyte_d      = '0;
    pidx_d       = '0;
    status_d     = gbfp_pkg::ST_NONE;
    fl_ctrl.load = 1'b0;
    fl_ctrl.fold = 1'b0;

    unique case (phase_q)
      PH_SYNC1: begin
        if (rx_byte_i == gbfp_pkg::SYNC_FIRST) phase_d = PH_SYNC2;
      end
      PH_SYNC2: begin
        phase_d = (rx_byte_i == gbfp_pkg::SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
      end
      PH_CLASS: begin
        class_d      = rx_byte_i;
        fl_ctrl.load = 1'b1;
        phase_d      = PH_ID;
      end
      PH_ID: begin
        id_d         = rx_byte_i;
        fl_ctrl.fold = 1'b1;
        phase_d      = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        exp_len_d    = 16'(rx_byte_i);
        fl_ctrl.fold = 1'b1;
        phase_d      = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        exp_len_d    = hi_len;
        cnt_d        = '0;
        fl_ctrl.fold = 1'b1;
        if (hi_len > limit_ext) begin
          status_d = gbfp_pkg::ST_OVERSIZE;
          phase_d  = PH_SYNC1;
        end else if (hi_len == 16'd0) begin
          phase_d = PH_CK_A;
        end else begin
          phase_d = PH_DATA;
        end
      end
      PH_DATA: begin
        fl_ctrl.fold = 1'b1;
        pv_d         = 1'b1;
        pbyte_d      = rx_byte_i;
        pidx_d       = gbfp_pkg::IdxW'(cnt_q);
        cnt_d        = cnt_inc;
        if (16'(cnt_inc) >= exp_len_q) phase_d = PH_CK_A;
      end
      PH_CK_A: begin
        if (rx_byte_i != sum_a) begin
          status_d = gbfp_pkg::ST_BAD_A;
          phase_d  = PH_SYNC1;
        end else begin
          phase_d = PH_CK_B;
        end
      end
      PH_CK_B: begin
        status_d = (rx_byte_i == sum_b) ? gbfp_pkg::ST_GOOD : gbfp_pkg::ST_BAD_B;
        phase_d  = PH_SYNC1;
      end
      default: begin
        phase_d = PH_SYNC1;
      end
    endcase

    if (!in_xfer) begin
      fl_ctrl.load = 1'b0;
      fl_ctrl.fold = 1'b0;
    end

    flen_d = (exp_len_d <= limit_ext) ? exp_len_d[gbfp_pkg::LenRegW-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SYNC1;
      max_len_q   <= gbfp_pkg::MaxLenReset;
      class_q     <= '0;
      id_q        <= '0;
      exp_len_q   <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      pv_q        <= 1'b0;
      pbyte_q     <= '0;
      pidx_q      <= '0;
      status_q    <= gbfp_pkg::ST_NONE;
      flen_q      <= '0;
    end else begin
      if (cfg_we_i) max_len_q <= cfg_wdata_i;
      if (in_xfer) begin
        phase_q     <= phase_d;
        class_q     <= class_d;
        id_q        <= id_d;
        exp_len_q   <= exp_len_d;
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
        pv_q        <= pv_d;
        pbyte_q     <= pbyte_d;
        pidx_q      <= pidx_d;
        status_q    <= status_d;
        flen_q      <= flen_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign payload_valid_o = pv_q;
  assign payload_byte_o  = pbyte_q;
  assign payload_index_o = pidx_q;
  assign frame_status_o  = status_q;
  assign frame_class_o   = class_q;
  assign frame_id_o      = id_q;
  assign frame_length_o  = flen_q;

  `GBFP_ASSERT_NEXT(a_xfer_gives_result, clk_i, rst_ni, in_xfer, out_valid_q)
  `GBFP_ASSERT_NOW(a_payload_no_status, clk_i, rst_ni, out_valid_q && pv_q,
                   status_q == gbfp_pkg::ST_NONE)
  `GBFP_ASSERT_NOW(a_data_count_in_range, clk_i, rst_ni, phase_q == PH_DATA,
                   16'(cnt_q) < exp_len_q)
  `GBFP_ASSERT_NOW(a_oversize_no_length, clk_i, rst_ni,
                   out_valid_q && status_q == gbfp_pkg::ST_OVERSIZE, flen_q == '0)

endmodule

`default_nettype wire
